>>> hdl/hcbd_pkg.sv
// Shared constants, result type and hex decode for the chunked body decoder.
`timescale 1ns / 1ps

package hcbd_pkg;

  // Default parameter values
  localparam int SIZE_DIGITS_DEF = 8;
  localparam int TOTAL_BITS_DEF  = 40;

  // Fixed widths
  localparam int BYTE_W      = 8;
  localparam int ACC_W       = 32;
  localparam int DCOUNT_W    = 4;
  localparam int SKIP_W      = 2;
  localparam int TOTAL_OUT_W = 40;

  // Delimiter characters
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

  // Number of delimiter bytes dropped after each chunk
  localparam logic [SKIP_W-1:0] DELIM_BYTES = 2'd2;

  // One result transaction
  typedef struct packed {
    logic [BYTE_W-1:0]      out_byte;
    logic                   out_valid;
    logic                   body_done;
    logic                   format_error;
    logic [TOTAL_OUT_W-1:0] total_size;
  } res_t;

  // Hex digit decode: bit 4 set means the character is a hex digit
  function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

>>> hdl/hcbd_core.sv
// Parser state and per-byte update for the chunked body decoder.
`timescale 1ns / 1ps

module hcbd_core #(
  parameter int SIZE_DIGITS = hcbd_pkg::SIZE_DIGITS_DEF,
  parameter int TOTAL_BITS  = hcbd_pkg::TOTAL_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [hcbd_pkg::BYTE_W-1:0] in_byte,
  output hcbd_pkg::res_t              res
);
  import hcbd_pkg::*;

  localparam int SUM_W = ((TOTAL_BITS > ACC_W) ? TOTAL_BITS : ACC_W) + 1;

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_SIZE_LF,
    PH_DATA,
    PH_SKIP,
    PH_SKIP_LAST,
    PH_DONE,
    PH_ERROR
  } phase_t;

  phase_t                phase, phase_next;
  logic [ACC_W-1:0]      size_acc, size_acc_next;
  logic [DCOUNT_W-1:0]   digit_count, digit_count_next;
  logic [ACC_W-1:0]      bytes_rem, bytes_rem_next;
  logic [SKIP_W-1:0]     delim_skip, delim_skip_next;
  logic [TOTAL_BITS-1:0] running_total, running_total_next;

  logic [4:0]             hex;
  logic [SUM_W-1:0]       sum;
  logic [SKIP_W-1:0]      skip_dec;
  logic [TOTAL_OUT_W-1:0] total_show;
  logic [BYTE_W-1:0]      pass_byte;
  logic                   pass_valid;

  assign hex      = hex_decode(in_byte);
  assign sum      = SUM_W'(running_total) + SUM_W'(size_acc);
  assign skip_dec = delim_skip - SKIP_W'(1);

  // Next-state logic for one byte
  always_comb begin
    phase_next         = phase;
    size_acc_next      = size_acc;
    digit_count_next   = digit_count;
    bytes_rem_next     = bytes_rem;
    delim_skip_next    = delim_skip;
    running_total_next = running_total;
    pass_byte          = '0;
    pass_valid         = 1'b0;

    unique case (phase)
      PH_SIZE: begin
        if (hex[4]) begin
          if (digit_count >= DCOUNT_W'(SIZE_DIGITS)) begin
            phase_next = PH_ERROR;
          end else begin
            // saturate once a further digit would overflow
            if (|size_acc[ACC_W-1:ACC_W-4]) begin
              size_acc_next = '1;
            end else begin
              size_acc_next = {size_acc[ACC_W-5:0], hex[3:0]};
            end
            digit_count_next = digit_count + DCOUNT_W'(1);
          end
        end else if (in_byte == CHAR_CR && digit_count != '0) begin
          phase_next = PH_SIZE_LF;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_SIZE_LF: begin
        if (in_byte != CHAR_LF) begin
          phase_next = PH_ERROR;
        end else begin
          // saturating add of the chunk size
          if (|sum[SUM_W-1:TOTAL_BITS]) begin
            running_total_next = '1;
          end else begin
            running_total_next = sum[TOTAL_BITS-1:0];
          end
          bytes_rem_next = size_acc;
          if (size_acc == '0) begin
            delim_skip_next = DELIM_BYTES;
            phase_next      = PH_SKIP_LAST;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        pass_byte      = in_byte;
        pass_valid     = 1'b1;
        bytes_rem_next = bytes_rem - ACC_W'(1);
        if (bytes_rem == ACC_W'(1)) begin
          delim_skip_next = DELIM_BYTES;
          phase_next      = PH_SKIP;
        end
      end
      PH_SKIP, PH_SKIP_LAST: begin
        delim_skip_next = skip_dec;
        if (skip_dec == '0) begin
          if (phase == PH_SKIP_LAST) begin
            phase_next = PH_DONE;
          end else begin
            phase_next       = PH_SIZE;
            size_acc_next    = '0;
            digit_count_next = '0;
          end
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_ERROR;
      end
    endcase
  end

  // Shown total saturates at the output width
  generate
    if (TOTAL_BITS > TOTAL_OUT_W) begin : g_total_sat
      assign total_show = (|running_total_next[TOTAL_BITS-1:TOTAL_OUT_W]) ?
                          '1 : running_total_next[TOTAL_OUT_W-1:0];
    end else begin : g_total_ext
      assign total_show = TOTAL_OUT_W'(running_total_next);
    end
  endgenerate

  // Result for this byte
  assign res = '{
    out_byte:     pass_byte,
    out_valid:    pass_valid,
    body_done:    (phase_next == PH_DONE),
    format_error: (phase_next == PH_ERROR),
    total_size:   total_show
  };

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SIZE;
      size_acc      <= '0;
      digit_count   <= '0;
      bytes_rem     <= '0;
      delim_skip    <= '0;
      running_total <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      size_acc      <= size_acc_next;
      digit_count   <= digit_count_next;
      bytes_rem     <= bytes_rem_next;
      delim_skip    <= delim_skip_next;
      running_total <= running_total_next;
    end
  end

endmodule

>>> hdl/hcbd_out_buf.sv
// Two-entry result buffer: output register plus skid entry.
`timescale 1ns / 1ps

module hcbd_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hcbd_pkg::res_t push_res,
  output logic           full,
  output logic           result_valid,
  input  logic           result_stall,
  output hcbd_pkg::res_t head
);
  import hcbd_pkg::*;

  logic main_valid;
  logic skid_valid;
  res_t skid;
  logic take;

  assign take         = main_valid && !result_stall;
  assign result_valid = main_valid;
  assign full         = skid_valid;

  // Control: skid only fills while the head is held
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (take || !main_valid) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      main_valid <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (push) begin
      if (take || !main_valid) begin
        head <= push_res;
      end else begin
        skid <= push_res;
      end
    end else if (take && skid_valid) begin
      head <= skid;
    end
  end

endmodule

>>> hdl/http_chunked_body_decoder.sv
// Top level of the HTTP/1.1 chunked transfer body decoder.
//
// Input channel: in_valid / in_stall carry one raw body byte (in_byte) per
// transaction. Output channel: result_valid / result_stall carry one result
// per input byte: out_byte, out_valid (byte is chunk payload), body_done,
// format_error (sticky) and total_size (sum of announced chunk sizes).
// Each result is registered in the output register, or in the skid entry.
// Throughput: one byte per cycle while in_stall is low; the parser update is
// combinational between the parser state registers and the result register.
// A two-entry result buffer (output register plus skid entry) lets a byte be
// accepted while the previous result waits; in_stall rises only when both
// entries hold results, i.e. after the receiver stalled while a byte came in.
// Reset (rst, synchronous) returns the parser to the start of a size line,
// clears the total and empties the result buffer; no clearing pass.
// After an error or the end of the body every further byte still yields a
// result with out_valid low.
`timescale 1ns / 1ps

module http_chunked_body_decoder #(
  parameter int SIZE_DIGITS = hcbd_pkg::SIZE_DIGITS_DEF,
  parameter int TOTAL_BITS  = hcbd_pkg::TOTAL_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [hcbd_pkg::BYTE_W-1:0]      in_byte,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [hcbd_pkg::BYTE_W-1:0]      out_byte,
  output logic                             out_valid,
  output logic                             body_done,
  output logic                             format_error,
  output logic [hcbd_pkg::TOTAL_OUT_W-1:0] total_size
);
  import hcbd_pkg::*;

  logic accept;
  logic full;
  res_t res;
  res_t head;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  hcbd_core #(
    .SIZE_DIGITS (SIZE_DIGITS),
    .TOTAL_BITS  (TOTAL_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .res     (res)
  );

  hcbd_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (accept),
    .push_res     (res),
    .full         (full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .head         (head)
  );

  assign out_byte     = head.out_byte;
  assign out_valid    = head.out_valid;
  assign body_done    = head.body_done;
  assign format_error = head.format_error;
  assign total_size   = head.total_size;

endmodule

>>> hdl/hcbd_checker.sv
// Port-level checks for the chunked body decoder, bound to the top level.
`timescale 1ns / 1ps

module hcbd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [hcbd_pkg::BYTE_W-1:0]      in_byte,
  input logic                             result_valid,
  input logic                             result_stall,
  input logic [hcbd_pkg::BYTE_W-1:0]      out_byte,
  input logic                             out_valid,
  input logic                             body_done,
  input logic                             format_error,
  input logic [hcbd_pkg::TOTAL_OUT_W-1:0] total_size
);
  import hcbd_pkg::*;

  // Reset leaves both sides empty and ready
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !in_stall && !result_valid)
    else $error("buffer not empty after reset");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(out_byte) && $stable(out_valid) &&
      $stable(total_size) && $stable(format_error))
    else $error("stalled result changed");

  // Input is only stalled while a result is waiting
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> result_valid)
    else $error("input stalled with no result pending");

  // A payload byte is never flagged as end of body or error
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && out_valid |-> !body_done && !format_error)
    else $error("payload byte with done or error");

  // End of body and error exclude each other
  a_done_xor_err: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(body_done && format_error))
    else $error("done and error together");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (.*);

>>> tb/sv/tb_http_chunked_body_decoder.sv
// Self-checking testbench for the chunked body decoder: byte stream in, one result per byte out.
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder;
  import hcbd_pkg::*;

  localparam int SIZE_DIGITS = SIZE_DIGITS_DEF;
  localparam int STALL_LIMIT = 1000;   // cycles with no transaction before giving up
  localparam int HOLDOFF_CYCLES = 60;  // long receiver stall to fill the result buffer
  localparam int DRAIN_CYCLES = 10;

  // Where the parser is within the chunked body
  typedef enum logic [2:0] {
    SIZE_LINE, SIZE_LF, PAYLOAD, DELIM, LAST_DELIM, BODY_END, BAD_FORMAT
  } parse_phase_t;

  // How the generated body finishes
  typedef enum int {
    END_ZERO_CHUNK, END_BAD_CHAR, END_LONE_CR, END_EMPTY_LINE, END_OVERLONG, END_HUGE_CHUNK
  } body_end_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [BYTE_W-1:0]      in_byte = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [BYTE_W-1:0]      out_byte;
  logic                   out_valid;
  logic                   body_done;
  logic                   format_error;
  logic [TOTAL_OUT_W-1:0] total_size;

  logic [BYTE_W-1:0] raw_bytes_q[$];
  res_t              decoded_q[$];
  int                stim_total = 0;
  int                accepted_cnt = 0;
  int                mismatch_cnt = 0;
  int                idle_cycles = 0;
  int                tx_idle_pct;
  int                rx_idle_pct;
  int                holdoff_left = 0;
  logic              holdoff_done = 1'b0;

  // Predictor state
  parse_phase_t           ph = SIZE_LINE;
  logic [ACC_W-1:0]       size_acc = '0;
  logic [DCOUNT_W-1:0]    digit_cnt = '0;
  logic [ACC_W-1:0]       remaining = '0;
  logic [SKIP_W-1:0]      skip_cnt = '0;
  logic [TOTAL_OUT_W-1:0] total = '0;

  http_chunked_body_decoder DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .out_valid    (out_valid),
    .body_done    (body_done),
    .format_error (format_error),
    .total_size   (total_size)
  );

  always #5 clk = ~clk;

  // -1 for anything that is not a hex digit
  function automatic int hex_digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  // Expected result for one accepted byte; advances the predictor state
  function automatic res_t decode_byte(input logic [7:0] c);
    res_t        r;
    int          d;
    logic [40:0] sum;
    r = '0;
    d = hex_digit_value(c);
    case (ph)
      SIZE_LINE: begin
        if (d >= 0) begin
          if (digit_cnt >= SIZE_DIGITS) begin
            ph = BAD_FORMAT;
          end else begin
            if (size_acc > 32'h0FFF_FFFF) size_acc = '1;
            else size_acc = {size_acc[27:0], d[3:0]};
            digit_cnt = digit_cnt + 1'b1;
          end
        end else if (c == CHAR_CR && digit_cnt != 0) begin
          ph = SIZE_LF;
        end else begin
          ph = BAD_FORMAT;
        end
      end
      SIZE_LF: begin
        if (c != CHAR_LF) begin
          ph = BAD_FORMAT;
        end else begin
          sum = {1'b0, total} + size_acc;
          total = sum[40] ? '1 : sum[39:0];
          remaining = size_acc;
          if (size_acc == 0) begin
            skip_cnt = DELIM_BYTES;
            ph = LAST_DELIM;
          end else begin
            ph = PAYLOAD;
          end
        end
      end
      PAYLOAD: begin
        r.out_byte = c;
        r.out_valid = 1'b1;
        remaining = remaining - 1'b1;
        if (remaining == 0) begin
          skip_cnt = DELIM_BYTES;
          ph = DELIM;
        end
      end
      DELIM, LAST_DELIM: begin
        skip_cnt = skip_cnt - 1'b1;
        if (skip_cnt == 0) begin
          if (ph == LAST_DELIM) begin
            ph = BODY_END;
          end else begin
            ph = SIZE_LINE;
            size_acc = '0;
            digit_cnt = '0;
          end
        end
      end
      BODY_END: ;
      default: ph = BAD_FORMAT;
    endcase
    r.body_done = (ph == BODY_END);
    r.format_error = (ph == BAD_FORMAT);
    r.total_size = total;
    return r;
  endfunction

  // Hex character for a nibble, letters in random case
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 10) return 8'h30 + nib;
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + nib - 10;
  endfunction

  // Size line digits with up to pad leading zeros, never beyond SIZE_DIGITS
  task automatic push_size(input logic [31:0] size, input int pad);
    int n;
    n = 1;
    while (n < 8 && (size >> (4 * n)) != 0) n++;
    n = (n + pad > SIZE_DIGITS) ? SIZE_DIGITS : n + pad;
    for (int i = n - 1; i >= 0; i--) raw_bytes_q.push_back(hex_char(size[4*i +: 4]));
  endtask

  // Delimiter after a chunk: normally CR LF, sometimes junk since it is not checked
  task automatic push_delim();
    if ($urandom_range(0, 7) == 0) begin
      raw_bytes_q.push_back(8'($urandom_range(0, 255)));
      raw_bytes_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      raw_bytes_q.push_back(CHAR_CR);
      raw_bytes_q.push_back(CHAR_LF);
    end
  endtask

  // Stimulus: directed chunks, random chunks, then one way of ending the body
  initial begin
    int          sz;
    int          pad;
    body_end_t   ending;
    logic [7:0]  b;

    // full-width size line, payload extremes, junk delimiter
    push_size(32'd2, SIZE_DIGITS);
    raw_bytes_q.push_back(CHAR_CR);
    raw_bytes_q.push_back(CHAR_LF);
    raw_bytes_q.push_back(8'h00);
    raw_bytes_q.push_back(8'hFF);
    raw_bytes_q.push_back(8'hA5);
    raw_bytes_q.push_back(8'h5A);
    // single-byte chunk
    push_size(32'd1, 0);
    raw_bytes_q.push_back(CHAR_CR);
    raw_bytes_q.push_back(CHAR_LF);
    raw_bytes_q.push_back(8'h80);
    push_delim();

    // random well-formed chunks, mostly short
    while (raw_bytes_q.size() < 1380) begin
      sz = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, SIZE_DIGITS) : 0;
      push_size(sz, pad);
      raw_bytes_q.push_back(CHAR_CR);
      raw_bytes_q.push_back(CHAR_LF);
      repeat (sz) raw_bytes_q.push_back(8'($urandom_range(0, 255)));
      push_delim();
    end

    // only one ending per run, since the block is reset once
    ending = body_end_t'($urandom_range(0, 5));
    case (ending)
      END_ZERO_CHUNK: begin
        push_size(32'd0, $urandom_range(0, SIZE_DIGITS));
        raw_bytes_q.push_back(CHAR_CR);
        raw_bytes_q.push_back(CHAR_LF);
        push_delim();
      end
      END_BAD_CHAR: begin
        if ($urandom_range(0, 1)) push_size($urandom_range(1, 255), 0);
        do b = 8'($urandom_range(0, 255));
        while (hex_digit_value(b) >= 0 || b == CHAR_CR);
        raw_bytes_q.push_back(b);
      end
      END_LONE_CR: begin
        push_size($urandom_range(1, 255), 0);
        raw_bytes_q.push_back(CHAR_CR);
        do b = 8'($urandom_range(0, 255));
        while (b == CHAR_LF);
        raw_bytes_q.push_back(b);
      end
      END_EMPTY_LINE: begin
        raw_bytes_q.push_back(CHAR_CR);
        raw_bytes_q.push_back(CHAR_LF);
      end
      END_OVERLONG: begin
        push_size($urandom(), SIZE_DIGITS);
        raw_bytes_q.push_back(hex_char(4'($urandom_range(0, 15))));
      end
      default: begin
        // announced size far larger than what follows: sets bit 31 of the total
        push_size(32'h8000_0000 | $urandom(), 0);
        raw_bytes_q.push_back(CHAR_CR);
        raw_bytes_q.push_back(CHAR_LF);
        repeat (30) raw_bytes_q.push_back(8'($urandom_range(0, 255)));
      end
    endcase
    // trailing bytes after the end or the error
    repeat (10) raw_bytes_q.push_back(8'($urandom_range(0, 255)));
    stim_total = raw_bytes_q.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (rst) @(posedge clk);
    while (raw_bytes_q.size() != 0 || in_valid) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Idling mix by progress: sender light/receiver heavy, swapped, then none
  always_comb begin
    if (accepted_cnt < stim_total / 3) begin
      tx_idle_pct = 17;
      rx_idle_pct = 52;
    end else if (accepted_cnt < 2 * stim_total / 3) begin
      tx_idle_pct = 52;
      rx_idle_pct = 17;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  end

  // Driver: predicts each accepted byte, then offers the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decoded_q.push_back(decode_byte(in_byte));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_valid || !in_stall) begin
        if (raw_bytes_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          in_byte <= raw_bytes_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    // print only the first couple of hundred to keep the log readable
    if (mismatch_cnt < 200)
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  // Monitor: checks each result transaction and drives the receiver stall
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", out_byte, 0);
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.out_byte)
            report_mismatch("out_byte", out_byte, want.out_byte);
          if (out_valid !== want.out_valid)
            report_mismatch("out_valid", out_valid, want.out_valid);
          if (body_done !== want.body_done)
            report_mismatch("body_done", body_done, want.body_done);
          if (format_error !== want.format_error)
            report_mismatch("format_error", format_error, want.format_error);
          if (total_size !== want.total_size)
            report_mismatch("total_size", total_size, want.total_size);
        end
      end
      // one long hold-off early in the no-idle stretch so the input backs up
      if (!holdoff_done && accepted_cnt >= 2 * stim_total / 3 + 40) begin
        holdoff_done <= 1'b1;
        holdoff_left <= HOLDOFF_CYCLES;
        result_stall <= 1'b1;
      end else if (holdoff_left > 0) begin
        holdoff_left <= holdoff_left - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  // Watchdog: no transaction on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
